// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL; compiled out when SYNTH is set.
// Depends on nothing; users must have a clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define FRT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
`define FRT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) else $error("assertion failed");
`else
`define FRT_ASSERT(lbl, prop)
`define FRT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- rtl/frt_pkg.sv -----
// Shared constants and types for the least-loaded flow router.
// No dependencies.
`timescale 1ns / 1ps
package frt_pkg;
   localparam int TABLE_ENTRIES = 256;
   localparam int NUM_ACTORS    = 8;
   localparam int TBL_AW        = $clog2(TABLE_ENTRIES);
   localparam int ACT_W         = 3;
   localparam int LOAD_W        = 9;
   localparam int KEY_W         = 64;
   localparam int CNT_W         = 4;
   localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
   localparam logic [CNT_W-1:0] ACNT_RESET = CNT_W'(NUM_ACTORS);

   localparam logic [1:0] REQ_ASSIGN  = 2'd0;
   localparam logic [1:0] REQ_RELEASE = 2'd1;
   localparam logic [1:0] REQ_RR      = 2'd2;

   localparam logic [2:0] ST_NEW      = 3'd0;
   localparam logic [2:0] ST_FOUND    = 3'd1;
   localparam logic [2:0] ST_RELEASED = 3'd2;
   localparam logic [2:0] ST_MISS     = 3'd3;
   localparam logic [2:0] ST_FULL     = 3'd4;

   // running minimum handed from cell to cell
   typedef struct packed {
      logic              found;
      logic [LOAD_W-1:0] load;
      logic [ACT_W-1:0]  idx;
   } chain_type;

   typedef struct packed {
      logic active;
      logic inc;
      logic dec;
   } cell_ctl_type;
endpackage

// ----- rtl/frt_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module frt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/frt_cell.sv -----
// One actor cell: holds a saturating load count and takes part in the
// registered minimum chain. Depends on frt_pkg.
`timescale 1ns / 1ps
module frt_cell import frt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [ACT_W-1:0] cell_idx,
   input  cell_ctl_type     ctl,
   input  chain_type        chain_in,
   output chain_type        chain_out
);
   logic [LOAD_W-1:0] load_ff, load_in;
   chain_type         chain_ff, chain_in_sel;

   always_comb begin
      load_in = load_ff;
      if (ctl.inc && load_ff != LOAD_MAX) begin
         load_in = load_ff + LOAD_W'(1);
      end else if (ctl.dec && load_ff != '0) begin
         load_in = load_ff - LOAD_W'(1);
      end
      // strict less-than keeps the lower index on ties
      chain_in_sel = chain_in;
      if (ctl.active && (!chain_in.found || load_ff < chain_in.load)) begin
         chain_in_sel = '{found: 1'b1, load: load_ff, idx: cell_idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= '0;
         chain_ff <= '0;
      end else begin
         load_ff  <= load_in;
         chain_ff <= chain_in_sel;
      end
   end

   assign chain_out = chain_ff;
endmodule

// ----- rtl/least_loaded_flow_router_top.sv -----
// Top level of the sticky least-loaded flow router.
// Depends on frt_pkg, frt_ram, frt_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   req_* carries one word (request type, 64-bit routing key) with
//   valid/ready; rsp_* returns one word (actor index, status) per request.
//   csr_wr_en/csr_wr_data write actor_count; write only while idle.
// Latency and throughput:
//   Assign and release sweep the flow table RAM one entry per cycle,
//   comparing each registered read against the key and noting the first
//   free entry; a decide state follows the sweep, then the response.
//   Round robin and unknown types answer in the cycle after accept.
//   One request at a time; req_ready is high only while idle.
//   The least-loaded actor comes from a row of load cells that pass a
//   registered running minimum along, settled long before the sweep ends.
// Reset:
//   Clears valid bits, loads, round-robin position; actor_count -> 8.
//   The key RAM needs no clearing; an entry's key is only used when valid.
// Stall:
//   The response holds in its output register until rsp_ready.
module least_loaded_flow_router_top import frt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_type,
   input  logic [KEY_W-1:0] req_routing_key,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [ACT_W-1:0] rsp_actor_index,
   output logic [2:0]       rsp_status,
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SWEEP  = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;
   localparam logic [1:0] S_RESP   = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [1:0]             type_ff, type_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [TBL_AW:0]        cnt_ff, cnt_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [TBL_AW-1:0]      chk_idx_ff, chk_idx_in;
   logic                   hit_ff, hit_in, free_ff, free_in;
   logic [TBL_AW-1:0]      hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in;
   logic [ACT_W-1:0]       hit_act_ff, hit_act_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [ACT_W-1:0]       rr_ff, rr_in;
   logic [CNT_W-1:0]       acnt_ff;
   logic [ACT_W-1:0]       rsp_act_ff, rsp_act_in;
   logic [2:0]             rsp_st_ff, rsp_st_in;

   logic [CNT_W-1:0]       n_eff;
   logic [CNT_W-1:0]       rr_cur, rr_next;
   logic                   ram_we;
   logic [KEY_W+ACT_W-1:0] ram_rdata;
   logic [KEY_W-1:0]       rd_key;
   logic [ACT_W-1:0]       rd_act, best;
   logic                   do_inc, do_dec;
   chain_type              chain [NUM_ACTORS+1];
   cell_ctl_type           ctl [NUM_ACTORS];

   assign n_eff = (acnt_ff == '0) ? CNT_W'(1) :
                  (acnt_ff > CNT_W'(NUM_ACTORS)) ? CNT_W'(NUM_ACTORS) : acnt_ff;
   assign rr_cur  = ({1'b0, rr_ff} >= n_eff) ? '0 : {1'b0, rr_ff};
   assign rr_next = ((rr_cur + CNT_W'(1)) >= n_eff) ? '0 : rr_cur + CNT_W'(1);

   assign rd_key = ram_rdata[KEY_W+ACT_W-1:ACT_W];
   assign rd_act = ram_rdata[ACT_W-1:0];
   assign best   = chain[NUM_ACTORS].idx;

   frt_ram #(.WIDTH(KEY_W + ACT_W), .DEPTH(TABLE_ENTRIES)) u_tbl (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (free_idx_ff),
      .wr_data ({key_ff, best}),
      .rd_addr (cnt_ff[TBL_AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign chain[0] = '0;
   for (genvar k = 0; k < NUM_ACTORS; k++) begin : g_cell
      assign ctl[k].active = CNT_W'(k) < n_eff;
      assign ctl[k].inc    = do_inc && best == ACT_W'(k);
      assign ctl[k].dec    = do_dec && hit_act_ff == ACT_W'(k);
      frt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (ACT_W'(k)),
         .ctl       (ctl[k]),
         .chain_in  (chain[k]),
         .chain_out (chain[k+1])
      );
   end

   always_comb begin
      state_in    = state_ff;
      type_in     = type_ff;
      key_in      = key_ff;
      cnt_in      = cnt_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_act_in  = hit_act_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      valid_in    = valid_ff;
      rr_in       = rr_ff;
      rsp_act_in  = rsp_act_ff;
      rsp_st_in   = rsp_st_ff;
      ram_we      = 1'b0;
      do_inc      = 1'b0;
      do_dec      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               type_in = req_type;
               key_in  = req_routing_key;
               cnt_in  = '0;
               hit_in  = 1'b0;
               free_in = 1'b0;
               if (req_type == REQ_ASSIGN || req_type == REQ_RELEASE) begin
                  state_in = S_SWEEP;
               end else if (req_type == REQ_RR) begin
                  rsp_act_in = rr_cur[ACT_W-1:0];
                  rsp_st_in  = ST_NEW;
                  rr_in      = rr_next[ACT_W-1:0];
                  state_in   = S_RESP;
               end else begin
                  rsp_act_in = '0;
                  rsp_st_in  = ST_MISS;
                  state_in   = S_RESP;
               end
            end
         end
         S_SWEEP: begin
            if (!cnt_ff[TBL_AW]) begin
               cnt_in     = cnt_ff + (TBL_AW+1)'(1);
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[TBL_AW-1:0];
            end
            // RAM data arrives in the cycle after its address
            if (chk_vld_ff) begin
               if (valid_ff[chk_idx_ff] && rd_key == key_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = chk_idx_ff;
                  hit_act_in = rd_act;
               end
               if (!valid_ff[chk_idx_ff] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
            end else if (cnt_ff[TBL_AW]) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            if (type_ff == REQ_ASSIGN) begin
               if (hit_ff) begin
                  rsp_act_in = hit_act_ff;
                  rsp_st_in  = ST_FOUND;
               end else if (free_ff) begin
                  ram_we                = 1'b1;
                  valid_in[free_idx_ff] = 1'b1;
                  do_inc                = 1'b1;
                  rsp_act_in            = best;
                  rsp_st_in             = ST_NEW;
               end else begin
                  rsp_act_in = '0;
                  rsp_st_in  = ST_FULL;
               end
            end else begin
               if (hit_ff) begin
                  valid_in[hit_idx_ff] = 1'b0;
                  do_dec               = 1'b1;
                  rsp_act_in           = hit_act_ff;
                  rsp_st_in            = ST_RELEASED;
               end else begin
                  rsp_act_in = '0;
                  rsp_st_in  = ST_MISS;
               end
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         valid_ff   <= '0;
         rr_ff      <= '0;
         acnt_ff    <= ACNT_RESET;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         valid_ff   <= valid_in;
         rr_ff      <= rr_in;
         if (csr_wr_en) begin
            acnt_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      key_ff      <= key_in;
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      hit_act_ff  <= hit_act_in;
      free_ff     <= free_in;
      free_idx_ff <= free_idx_in;
      rsp_act_ff  <= rsp_act_in;
      rsp_st_ff   <= rsp_st_in;
   end

   assign req_ready       = state_ff == S_IDLE;
   assign rsp_valid       = state_ff == S_RESP;
   assign rsp_actor_index = rsp_act_ff;
   assign rsp_status      = rsp_st_ff;

   `FRT_ASSERT(a_one_side, !(req_ready && rsp_valid))
   `FRT_ASSERT(a_full_zero, (rsp_valid && rsp_status == ST_FULL) |-> rsp_actor_index == '0)
   `FRT_ASSERT(a_rsp_once, (rsp_valid && rsp_ready) |=> !rsp_valid)
   `FRT_ASSERT_ALWAYS(a_reset_idle, reset |=> (req_ready && !rsp_valid))
endmodule

// ----- tb/least_loaded_flow_router_top_tb.sv -----
// Self-checking testbench for least_loaded_flow_router_top: drives request words,
// predicts each response from a local flow table / load model, checks in order.
// Depends on frt_pkg and the RTL of least_loaded_flow_router_top.
`timescale 1ns / 1ps
module least_loaded_flow_router_top_tb;
   import frt_pkg::*;

   localparam logic [1:0] REQ_NONE = 2'd3;   // unused request type, answered as a miss
   localparam int STALL_LIMIT = 20000;
   localparam int HOLDOFF_CYCLES = 700;

   typedef struct {
      logic [1:0]       kind;
      logic [KEY_W-1:0] key;
   } route_word_type;

   typedef struct {
      logic [ACT_W-1:0] actor;
      logic [2:0]       status;
   } route_answer_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_type;
   logic [KEY_W-1:0] req_routing_key;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [ACT_W-1:0] rsp_actor_index;
   logic [2:0]       rsp_status;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   least_loaded_flow_router_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_routing_key(req_routing_key),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_actor_index(rsp_actor_index), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // local model of the router state
   logic [KEY_W-1:0] flow_key_m[TABLE_ENTRIES];
   logic             flow_used_m[TABLE_ENTRIES];
   logic [ACT_W-1:0] flow_actor_m[TABLE_ENTRIES];
   logic [LOAD_W-1:0] actor_load_m[NUM_ACTORS];
   logic [ACT_W-1:0] rr_pos_m;
   logic [CNT_W-1:0] actor_count_m;

   route_word_type   pending_words[$];
   route_answer_type expected_answers[$];
   logic [KEY_W-1:0] known_keys[$];

   int  idle_mode;          // 0 none, 1 sender, 2 receiver, 3 both
   int  req_accepts, req_seen;
   int  words_queued, answers_checked;
   int  holdoff_asked, holdoff_done, holdoff_left;
   int  errors;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic route_answer_type route_request(logic [1:0] kind, logic [KEY_W-1:0] key);
      route_answer_type ans;
      int n, hit, slot, best, p;
      ans.actor = '0;
      ans.status = ST_MISS;
      n = (actor_count_m == 0) ? 1 : (actor_count_m > NUM_ACTORS) ? NUM_ACTORS : actor_count_m;
      hit = -1;
      slot = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (hit < 0 && flow_used_m[i] && flow_key_m[i] == key) hit = i;
         if (slot < 0 && !flow_used_m[i]) slot = i;
      end
      case (kind)
         REQ_ASSIGN: begin
            if (hit >= 0) begin
               ans.actor = flow_actor_m[hit];
               ans.status = ST_FOUND;
            end else if (slot < 0) begin
               ans.status = ST_FULL;
            end else begin
               best = 0;
               for (int k = 1; k < n; k++)
                  if (actor_load_m[k] < actor_load_m[best]) best = k;
               flow_key_m[slot] = key;
               flow_used_m[slot] = 1'b1;
               flow_actor_m[slot] = best[ACT_W-1:0];
               if (actor_load_m[best] != LOAD_MAX) actor_load_m[best]++;
               ans.actor = best[ACT_W-1:0];
               ans.status = ST_NEW;
            end
         end
         REQ_RELEASE: begin
            if (hit >= 0) begin
               flow_used_m[hit] = 1'b0;
               if (actor_load_m[flow_actor_m[hit]] != 0) actor_load_m[flow_actor_m[hit]]--;
               ans.actor = flow_actor_m[hit];
               ans.status = ST_RELEASED;
            end
         end
         REQ_RR: begin
            p = rr_pos_m;
            if (p >= n) p = 0;
            ans.actor = p[ACT_W-1:0];
            ans.status = ST_NEW;
            p++;
            if (p >= n) p = 0;
            rr_pos_m = p[ACT_W-1:0];
         end
         default: ;
      endcase
      return ans;
   endfunction

   // response check first, then prediction of any word taken this edge
   always @(posedge clock) begin
      route_answer_type exp_ans;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_answers.size() == 0) begin
               $error("response with nothing expected: actor_index %0d status %0d",
                      rsp_actor_index, rsp_status);
               errors++;
            end else begin
               exp_ans = expected_answers.pop_front();
               answers_checked++;
               if (rsp_actor_index !== exp_ans.actor) begin
                  $error("actor_index: expected %0d, got %0d", exp_ans.actor, rsp_actor_index);
                  errors++;
               end
               if (rsp_status !== exp_ans.status) begin
                  $error("status: expected %0d, got %0d", exp_ans.status, rsp_status);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_answers.push_back(route_request(req_type, req_routing_key));
            req_accepts++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // sender
   always @(negedge clock) begin
      route_word_type w;
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         if (req_valid && req_accepts != req_seen) begin
            req_seen = req_accepts;
            offer = 1'b0;
         end
         if (!offer && pending_words.size() > 0) begin
            if (!((idle_mode == 1 && $urandom_range(99) < 51) ||
                  (idle_mode == 3 && $urandom_range(99) < 31))) begin
               w = pending_words.pop_front();
               req_type <= w.kind;
               req_routing_key <= w.key;
               offer = 1'b1;
            end
         end
      end
      req_valid <= offer;
   end

   // receiver, with a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (holdoff_asked != holdoff_done) begin
         holdoff_done = holdoff_asked;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else if (idle_mode == 2) begin
         rsp_ready <= ($urandom_range(99) >= 51);
      end else if (idle_mode == 3) begin
         rsp_ready <= ($urandom_range(99) >= 31);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic queue_word(logic [1:0] kind, logic [KEY_W-1:0] key);
      route_word_type w;
      w.kind = kind;
      w.key = key;
      pending_words.push_back(w);
      words_queued++;
      if (kind == REQ_ASSIGN) begin
         known_keys.push_back(key);
         if (known_keys.size() > 48) void'(known_keys.pop_front());
      end
   endtask

   // every queued word must have come back, not just left the queue
   task automatic wait_drained();
      while (answers_checked != words_queued || req_valid)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_actor_count(logic [CNT_W-1:0] value);
      wait_drained();
      csr_wr_data <= value;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      actor_count_m = value;
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      if (known_keys.size() > 0 && $urandom_range(2) != 0)
         return known_keys[$urandom_range(known_keys.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic queue_random(int count);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 50)      queue_word(REQ_ASSIGN, pick_key());
         else if (r < 80) queue_word(REQ_RELEASE, pick_key());
         else if (r < 95) queue_word(REQ_RR, {$urandom, $urandom});
         else             queue_word(REQ_NONE, {$urandom, $urandom});
      end
   endtask

   initial begin
      logic [CNT_W-1:0] counts[7] = '{4'd1, 4'd8, 4'd5, 4'd2, 4'd15, 4'd0, 4'd3};
      int live;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_ASSIGN;
      req_routing_key = '0;
      rsp_ready = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      idle_mode = 0;
      req_accepts = 0;
      req_seen = 0;
      words_queued = 0;
      answers_checked = 0;
      holdoff_asked = 0;
      holdoff_done = 0;
      holdoff_left = 0;
      errors = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         flow_used_m[i] = 1'b0;
         flow_key_m[i] = '0;
         flow_actor_m[i] = '0;
      end
      for (int i = 0; i < NUM_ACTORS; i++) actor_load_m[i] = '0;
      rr_pos_m = '0;
      actor_count_m = ACNT_RESET;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: key extremes, hit, miss, round robin wrap, unknown type
      queue_word(REQ_ASSIGN, '0);
      queue_word(REQ_ASSIGN, '1);
      queue_word(REQ_ASSIGN, '0);
      queue_word(REQ_ASSIGN, 64'h5555_5555_5555_5555);
      queue_word(REQ_ASSIGN, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_word(REQ_RELEASE, '0);
      queue_word(REQ_RELEASE, '0);
      queue_word(REQ_RELEASE, '1);
      for (int i = 0; i < 6; i++) queue_word(REQ_RR, '1);
      queue_word(REQ_NONE, '1);
      queue_word(REQ_ASSIGN, 64'h1);
      // shrink below the round-robin position and below stored actors
      write_actor_count(4'd2);
      queue_word(REQ_RR, '0);
      queue_word(REQ_ASSIGN, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_word(REQ_ASSIGN, 64'h2);
      queue_word(REQ_RELEASE, 64'h5555_5555_5555_5555);
      write_actor_count(4'd0);
      queue_word(REQ_ASSIGN, 64'h3);
      queue_word(REQ_RR, '0);
      write_actor_count(4'd15);
      queue_word(REQ_ASSIGN, 64'h4);
      queue_word(REQ_RR, '0);

      // random phases through every idle pattern and count setting
      for (int ph = 0; ph < 7; ph++) begin
         write_actor_count(counts[ph]);
         idle_mode = ph % 4;
         if (ph == 0) holdoff_asked++;
         queue_random(30);
      end

      // fill the table past full, then drain part of it
      write_actor_count(4'd8);
      idle_mode = 0;
      live = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) if (flow_used_m[i]) live++;
      for (int i = 0; i < TABLE_ENTRIES - live + 6; i++)
         queue_word(REQ_ASSIGN, {$urandom, $urandom});
      queue_word(REQ_ASSIGN, known_keys[0]);
      wait_drained();
      idle_mode = 3;
      for (int i = 0; i < 30; i++) queue_word(REQ_RELEASE, pick_key());
      queue_random(20);

      wait_drained();
      repeat (TABLE_ENTRIES + 20) @(negedge clock);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
